>>> hdl/ksi_pkg.sv
// Shared types, constants and register codes of the keyframe scale interpolator.
package ksi_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam int FUNC_W      = 1;
   localparam int ENTRY_W     = 10;
   localparam int VALUE_W     = 32;
   localparam int TIME_W      = 28;
   localparam int FRAC_W      = 12;
   localparam int FRAME_W     = TIME_W - FRAC_W;
   localparam int IDX_RAW_W   = 16;
   localparam int REM_W       = 14;
   localparam int SHIFT_W     = 2;
   localparam int PAIR_W      = 2 * VALUE_W;
   localparam int NARROW_W    = 16;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MODE_W      = 2;
   localparam int LAST_W      = 13;
   localparam int FRAMES_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INTERP_FRAME = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW_FORMAT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FRAMES        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_TO_START     = 3'd4;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_MUL,
      ST_RED_QD,
      ST_RED_FIX,
      ST_WRITE,
      ST_READ0,
      ST_READ1,
      ST_MULT,
      ST_SUM
   } ksi_state_type;

   typedef struct packed {
      logic capture;
      logic red_mul;
      logic red_qd;
      logic red_fix;
      logic mem_write;
      logic mem_read;
      logic rd_second;
      logic hold_a;
      logic mult;
      logic push;
   } ksi_cmd_type;

   typedef struct packed {
      logic is_query;
      logic out_free;
   } ksi_status_type;

endpackage

>>> hdl/ksi_channels_if.sv
// Channel interfaces of the keyframe scale interpolator: request, response and register write.
interface ksi_req_if
   import ksi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [ENTRY_W-1:0]        entry_index;
   logic signed [VALUE_W-1:0] scale_value;
   logic signed [VALUE_W-1:0] inverse_value;
   logic [TIME_W-1:0]         frame_time;

   modport source (output valid, func, entry_index, scale_value, inverse_value, frame_time,
                   input ready);
   modport sink   (input valid, func, entry_index, scale_value, inverse_value, frame_time,
                   output ready);
endinterface

interface ksi_rsp_if
   import ksi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] scale_out;
   logic signed [VALUE_W-1:0] inverse_out;

   modport source (output valid, scale_out, inverse_out, input ready);
   modport sink   (input valid, scale_out, inverse_out, output ready);
endinterface

interface ksi_csr_if
   import ksi_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/ksi_ctrl.sv
// Sequencing state machine of the keyframe scale interpolator.
module ksi_ctrl
   import ksi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ksi_status_type status,
   output ksi_cmd_type    cmd
);

   ksi_state_type state_ff;
   ksi_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RED_MUL;
            end
         end
         ST_RED_MUL: begin
            cmd.red_mul = 1'b1;
            state_in    = ST_RED_QD;
         end
         ST_RED_QD: begin
            cmd.red_qd = 1'b1;
            state_in   = ST_RED_FIX;
         end
         ST_RED_FIX: begin
            cmd.red_fix = 1'b1;
            state_in    = status.is_query ? ST_READ0 : ST_WRITE;
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ0: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_READ1;
         end
         ST_READ1: begin
            cmd.mem_read  = 1'b1;
            cmd.rd_second = 1'b1;
            cmd.hold_a    = 1'b1;
            state_in      = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Wait here until the response register has room.
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/ksi_datapath.sv
// Datapath of the keyframe scale interpolator: registers, index reduction, pair memory, blend.
module ksi_datapath
   import ksi_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ksi_cmd_type               cmd,
   output ksi_status_type            status,
   // request payload
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [ENTRY_W-1:0]        req_entry_index,
   input  logic signed [VALUE_W-1:0] req_scale_value,
   input  logic signed [VALUE_W-1:0] req_inverse_value,
   input  logic [TIME_W-1:0]         req_frame_time,
   // register writes
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   // response
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_scale_out,
   output logic signed [VALUE_W-1:0] rsp_inverse_out
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int XW = IDX_RAW_W;
   localparam int SW = XW + IW;
   localparam int RW = XW + 1;
   localparam int PW = XW + RW;
   localparam int DW = XW + 1;
   localparam logic [RW-1:0] RECIP_C = RW'((64'd1 << SW) / 64'(TABLE_DEPTH));
   localparam logic [DW-1:0] DEPTH_C = DW'(TABLE_DEPTH);
   localparam logic [DW-1:0] LAST_C  = DW'(TABLE_DEPTH - 1);

   // configuration registers
   logic [MODE_W-1:0]   mode_ff;
   logic [LAST_W-1:0]   last_ff;
   logic                narrow_ff;
   logic [FRAMES_W-1:0] frames_ff;
   logic                loop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         last_ff   <= '0;
         narrow_ff <= 1'b0;
         frames_ff <= FRAMES_W'(1);
         loop_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DECIMATION_MODE:   mode_ff   <= csr_data[MODE_W-1:0];
            CSR_LAST_INTERP_FRAME: last_ff   <= csr_data[LAST_W-1:0];
            CSR_NARROW_FORMAT:     narrow_ff <= csr_data[0];
            CSR_NUM_FRAMES:        frames_ff <= csr_data[FRAMES_W-1:0];
            CSR_LOOP_TO_START:     loop_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Capture: raw start index, fraction, shift and the wrap-to-zero flag.
   logic [FRAME_W-1:0]   frame;
   logic                 dec2;
   logic                 dec4;
   logic                 is_final;
   logic                 past_last;
   logic [XW-1:0]        x_in;
   logic [REM_W-1:0]     rem_in;
   logic [SHIFT_W-1:0]   shift_in;
   logic                 zero_in;
   logic [XW-1:0]        f_dec2;
   logic [XW-1:0]        f_dec4;
   logic [VALUE_W-1:0]   ld_scale_in;
   logic [VALUE_W-1:0]   ld_inv_in;

   assign frame     = req_frame_time[TIME_W-1:FRAC_W];
   assign dec2      = mode_ff[0];
   assign dec4      = !mode_ff[0] && mode_ff[1];
   assign is_final  = (frames_ff != '0) && (frame == frames_ff - FRAMES_W'(1));
   assign past_last = frame >= FRAME_W'(last_ff);
   assign f_dec2    = XW'(frame >> 1) + XW'(frame[0]);
   assign f_dec4    = XW'(frame >> 2) + XW'(frame[1:0]);

   always_comb begin
      x_in     = XW'(frame);
      rem_in   = REM_W'(req_frame_time[FRAC_W-1:0]);
      shift_in = '0;
      zero_in  = 1'b0;
      if (req_func == FUNC_LOAD) begin
         x_in = XW'(req_entry_index);
      end else if (is_final) begin
         zero_in = 1'b1;
         if (dec2) begin
            x_in = f_dec2;
         end else if (dec4) begin
            x_in = f_dec4;
         end
         // Without looping the entry comes back unblended: a zero fraction does that.
         if (!loop_ff) begin
            rem_in = '0;
         end
      end else if (dec2) begin
         if (past_last) begin
            x_in = XW'(last_ff >> 1);
         end else begin
            x_in     = XW'(frame >> 1);
            rem_in   = REM_W'(req_frame_time[FRAC_W:0]);
            shift_in = SHIFT_W'(1);
         end
      end else if (dec4) begin
         if (past_last) begin
            x_in = f_dec4;
         end else begin
            x_in     = XW'(frame >> 2);
            rem_in   = req_frame_time[FRAC_W+1:0];
            shift_in = SHIFT_W'(2);
         end
      end
   end

   always_comb begin
      ld_scale_in = req_scale_value;
      ld_inv_in   = req_inverse_value;
      if (narrow_ff) begin
         ld_scale_in = VALUE_W'($signed(req_scale_value[NARROW_W-1:0]));
         ld_inv_in   = VALUE_W'($signed(req_inverse_value[NARROW_W-1:0]));
      end
   end

   logic                 query_ff;
   logic [XW-1:0]        x_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   logic                 zero_ff;
   logic [PAIR_W-1:0]    ld_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= 1'b0;
      end else if (cmd.capture) begin
         query_ff <= (req_func == FUNC_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff       <= x_in;
         rem_ff     <= rem_in;
         shift_ff   <= shift_in;
         zero_ff    <= zero_in;
         ld_pair_ff <= {ld_scale_in, ld_inv_in};
      end
   end

   // Index reduction modulo the table depth: reciprocal multiply, back-multiply, one correction.
   logic [PW-1:0]    red_prod_ff;
   logic [PW-1:0]    red_prod_in;
   logic [XW-1:0]    quot;
   logic [XW+DW-1:0] qd_full;
   logic [XW-1:0]    qd_ff;
   logic [DW-1:0]    rdiff;
   logic [DW-1:0]    rfix;
   logic [IW-1:0]    idx0_ff;
   logic [IW-1:0]    idx1_ff;
   logic [IW-1:0]    idx0_in;
   logic [IW-1:0]    idx1_in;

   assign red_prod_in = PW'(x_ff) * PW'(RECIP_C);
   assign quot        = XW'(red_prod_ff >> SW);
   assign qd_full     = (XW+DW)'(quot) * (XW+DW)'(DEPTH_C);
   assign rdiff       = DW'(x_ff) - DW'(qd_ff);
   assign rfix        = (rdiff >= DEPTH_C) ? rdiff - DEPTH_C : rdiff;
   assign idx0_in     = IW'(rfix);
   assign idx1_in     = (zero_ff || rfix == LAST_C) ? '0 : IW'(rfix + DW'(1));

   always_ff @(posedge clock) begin
      if (cmd.red_mul) begin
         red_prod_ff <= red_prod_in;
      end
      if (cmd.red_qd) begin
         qd_ff <= XW'(qd_full);
      end
      if (cmd.red_fix) begin
         idx0_ff <= idx0_in;
         idx1_ff <= idx1_in;
      end
   end

   // Single-port pair memory, registered read.
   logic [PAIR_W-1:0] mem [TABLE_DEPTH];
   logic [PAIR_W-1:0] rd_ff;
   logic [IW-1:0]     rd_addr;

   assign rd_addr = cmd.rd_second ? idx1_ff : idx0_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[idx0_ff] <= ld_pair_ff;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Blend of both lanes. The scaled difference is shifted on its own so that the
   // shift keeps the sign.
   logic [PAIR_W-1:0]         a_ff;
   logic [VALUE_W-1:0]        diff_s;
   logic [VALUE_W-1:0]        diff_i;
   logic [VALUE_W-1:0]        prod_s_ff;
   logic [VALUE_W-1:0]        prod_i_ff;
   logic signed [VALUE_W-1:0] part_s;
   logic signed [VALUE_W-1:0] part_i;
   logic signed [VALUE_W-1:0] sum_s;
   logic signed [VALUE_W-1:0] sum_i;
   logic signed [VALUE_W-1:0] res_s;
   logic signed [VALUE_W-1:0] res_i;

   assign diff_s = rd_ff[PAIR_W-1:VALUE_W] - a_ff[PAIR_W-1:VALUE_W];
   assign diff_i = rd_ff[VALUE_W-1:0] - a_ff[VALUE_W-1:0];

   assign part_s = $signed(prod_s_ff) >>> FRAC_W;
   assign part_i = $signed(prod_i_ff) >>> FRAC_W;
   assign sum_s  = (a_ff[PAIR_W-1:VALUE_W] << shift_ff) + part_s;
   assign sum_i  = (a_ff[VALUE_W-1:0] << shift_ff) + part_i;
   assign res_s  = sum_s >>> shift_ff;
   assign res_i  = sum_i >>> shift_ff;

   always_ff @(posedge clock) begin
      if (cmd.hold_a) begin
         a_ff <= rd_ff;
      end
      if (cmd.mult) begin
         prod_s_ff <= VALUE_W'(diff_s * VALUE_W'(rem_ff));
         prod_i_ff <= VALUE_W'(diff_i * VALUE_W'(rem_ff));
      end
   end

   // Response register.
   logic                      out_valid_ff;
   logic signed [VALUE_W-1:0] out_scale_ff;
   logic signed [VALUE_W-1:0] out_inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_scale_ff <= res_s;
         out_inv_ff   <= res_i;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scale_out   = out_scale_ff;
   assign rsp_inverse_out = out_inv_ff;

   assign status.is_query = query_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

endmodule

>>> hdl/keyframe_scale_interpolator_top.sv
// Top level of the keyframe scale interpolator: channels, controller and datapath.
//
// Usage. Items arrive on the request channel; a beat with func set to load writes one
// (scale, inverse scale) pair into the table, a beat with func set to query gives a
// 16.12 frame time and yields exactly one response beat with the two blended values.
// Registers are written through the register channel, which is always ready; they are
// to be written only while the block is idle.
// Sequencing. The request channel is ready only while the sequencer is idle. After a
// query beat is accepted, the sequencer reduces the start index modulo the table depth
// (reciprocal multiply, back-multiply, correction), reads both entries one after the
// other from the single-port pair memory, does the blend multiply and then the final add
// and shift into the response register, and goes back to idle; so a new beat is taken
// only after the sequencer is done with the previous one. A load reduces its index the
// same way and then writes the table.
// Stalls. The response sits in its own register, so the block accepts and works on the
// next item while an earlier result waits; it only holds in its last step if that
// register is still full when the next result is ready.
// Reset clears the controller, the output valid and the registers to their defaults
// (num_frames one, all else zero). The table is not cleared: entries read before being
// loaded return arbitrary data.
module keyframe_scale_interpolator_top
   import ksi_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ksi_req_if.sink   req_bus,
   ksi_rsp_if.source rsp_bus,
   ksi_csr_if.sink   csr_bus
);

   ksi_cmd_type    cmd;
   ksi_status_type status;
   logic           ctrl_req_ready;

   // The register channel never stalls.
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = ctrl_req_ready;

   ksi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ksi_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_bus.func),
      .req_entry_index   (req_bus.entry_index),
      .req_scale_value   (req_bus.scale_value),
      .req_inverse_value (req_bus.inverse_value),
      .req_frame_time    (req_bus.frame_time),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_scale_out     (rsp_bus.scale_out),
      .rsp_inverse_out   (rsp_bus.inverse_out)
   );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the keyframe scale interpolator: table loads, blended queries, registers.
`timescale 1ns / 100ps

module tb_top
   import ksi_pkg::*;
();

   // Run sizes. SETTLE_CYCLES gives margin after the last response for a trailing load
   // to reach the table.
   localparam int DEPTH          = TABLE_DEPTH_DEFAULT;
   localparam int ITEM_TARGET    = 1350;
   localparam int CALM_ITEMS     = 160;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int MISMATCH_SHOWN = 10;

   // One blended pair, as the response channel carries it.
   typedef struct packed {
      logic [VALUE_W-1:0] scale;
      logic [VALUE_W-1:0] inverse;
   } blend_pair_type;

   // Which two entries a query reads and how it mixes them.
   typedef struct packed {
      logic [ENTRY_W-1:0] first;
      logic [ENTRY_W-1:0] second;
      logic [REM_W-1:0]   rem;
      logic [2:0]         step;
      logic [1:0]         shift;
      logic               raw;
   } read_plan_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_QUERY,
      ROW_REG
   } row_kind_type;

   // One line of the directed stimulus. Rows with typed set carry their own expected pair;
   // all other queries are checked against the predictor.
   typedef struct packed {
      row_kind_type       kind;
      reg_write_type      regw;
      logic [ENTRY_W-1:0] entry;
      logic [VALUE_W-1:0] scale;
      logic [VALUE_W-1:0] inverse;
      logic [TIME_W-1:0]  frame_time;
      logic               typed;
      blend_pair_type     exp;
   } stim_row_type;

   localparam reg_write_type  NO_REG_WRITE = '0;
   localparam blend_pair_type NO_BLEND     = '0;
   localparam blend_pair_type ENTRY0_PAIR  = '{32'h7FFF_FFFF, 32'h8000_0000};
   localparam blend_pair_type ENTRY1_PAIR  = '{32'h8000_0000, 32'h7FFF_FFFF};
   // Entry three is loaded while the narrow format is on, so both halves come out
   // sign-extended from their low sixteen bits.
   localparam blend_pair_type ENTRY3_PAIR  = '{32'hFFFF_8000, 32'h0000_7FFF};

   localparam int DIRECTED_COUNT = 47;

   // The directed part starts from the reset settings (every frame stored, one frame,
   // no loop, wide format) and then walks through each special case in turn.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Table contents used by the rest of the directed part, extremes first.
      '{ROW_LOAD, NO_REG_WRITE, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 28'h0, 1'b0, NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd1, 32'h8000_0000, 32'h7FFF_FFFF, 28'h0, 1'b0, NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd2, 32'h0001_2345, 32'hFFFF_8000, 28'h0, 1'b0, NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd1023, 32'h0000_1000, 32'hFFFF_F000, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd1022, 32'h1234_5678, 32'h8765_4321, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd4, 32'hDEAD_BEEF, 32'h0000_0001, 28'h0, 1'b0, NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd5, 32'h0000_FFFF, 32'hFFFF_0000, 28'h0, 1'b0, NO_BLEND},
      // With one frame, frame zero is the final frame and comes back unblended.
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_0000, 1'b1, ENTRY0_PAIR},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_0FFF, 1'b1, ENTRY0_PAIR},
      // Zero fraction returns the start entry itself.
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_1000, 1'b1, ENTRY1_PAIR},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_1FFF, 1'b0, NO_BLEND},
      // Largest frame time: both indices wrap round the table.
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'hFFF_FFFF, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h03F_E800, 1'b0, NO_BLEND},
      // The narrow format acts when a pair is loaded, not when it is read back.
      '{ROW_REG, '{CSR_NARROW_FORMAT, 16'd1}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_LOAD, NO_REG_WRITE, 10'd3, 32'h1234_8000, 32'hFFFF_7FFF, 28'h0, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_NARROW_FORMAT, 16'd0}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'd4}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_3000, 1'b1, ENTRY3_PAIR},
      // A zero frame count has no final frame at all.
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'd0}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_0000, 1'b1, ENTRY0_PAIR},
      // Looping: the final frame blends back toward entry zero.
      '{ROW_REG, '{CSR_LOOP_TO_START, 16'd1}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'd3}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_2800, 1'b0, NO_BLEND},
      // Every second frame, below and at or past the last interpolated frame.
      '{ROW_REG, '{CSR_DECIMATION_MODE, 16'd1}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_REG, '{CSR_LAST_INTERP_FRAME, 16'd8191}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'hFFFF}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_5800, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_LAST_INTERP_FRAME, 16'd4}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_6123, 1'b0, NO_BLEND},
      // Mode three behaves as every second frame.
      '{ROW_REG, '{CSR_DECIMATION_MODE, 16'd3}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_2ABC, 1'b0, NO_BLEND},
      // Every fourth frame, past and below the last interpolated frame.
      '{ROW_REG, '{CSR_DECIMATION_MODE, 16'd2}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_REG, '{CSR_LAST_INTERP_FRAME, 16'd0}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_7FFF, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_LAST_INTERP_FRAME, 16'd8191}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_6FFF, 1'b0, NO_BLEND},
      // Final frame under decimation, looped and then returned raw.
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'd7}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_6000, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_LOOP_TO_START, 16'd0}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_6000, 1'b1, ENTRY3_PAIR},
      '{ROW_REG, '{CSR_DECIMATION_MODE, 16'd1}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'd6}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'h000_5000, 1'b1, ENTRY3_PAIR},
      // Largest frame count: the final frame wraps to the top of the table and loops.
      '{ROW_REG, '{CSR_DECIMATION_MODE, 16'd0}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0,
        NO_BLEND},
      '{ROW_REG, '{CSR_NUM_FRAMES, 16'hFFFF}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_REG, '{CSR_LOOP_TO_START, 16'd1}, 10'd0, 32'h0, 32'h0, 28'h0, 1'b0, NO_BLEND},
      '{ROW_QUERY, NO_REG_WRITE, 10'd0, 32'h0, 32'h0, 28'hFFF_E000, 1'b0, NO_BLEND}
   };

   logic clock;
   logic reset;

   ksi_req_if req_if ();
   ksi_rsp_if rsp_if ();
   ksi_csr_if csr_if ();

   keyframe_scale_interpolator_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // The testbench's own copy of the table and the registers, kept up to date from the
   // beats that the block actually accepts.
   logic [VALUE_W-1:0] scale_table   [DEPTH];
   logic [VALUE_W-1:0] inverse_table [DEPTH];
   bit                 entry_loaded  [DEPTH];
   logic [MODE_W-1:0]   cfg_mode   = '0;
   logic [LAST_W-1:0]   cfg_last   = '0;
   logic                cfg_narrow = 1'b0;
   logic [FRAMES_W-1:0] cfg_frames = 16'd1;
   logic                cfg_loop   = 1'b0;

   // Blended pairs still owed by the block, oldest first.
   blend_pair_type expected_blends [$];

   // Expectation typed into the directed table for the beat now being offered.
   logic           typed_pending = 1'b0;
   blend_pair_type typed_blend   = '0;

   // Idling control shared by both sides: idle_on is chosen per phase, and the calm tail
   // at the end of the run has no idling at all.
   bit idle_on   = 1'b1;
   bit calm_tail = 1'b0;

   int cycle_count     = 0;
   int items_sent      = 0;
   int loads_sent      = 0;
   int queries_sent    = 0;
   int reg_writes      = 0;
   int settings_tried  = 0;
   int results_checked = 0;
   int mismatches      = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Works out which entries a query at frame time t reads under the current settings.
   // The frame number picks the start entry; the final frame and the decimation modes
   // change the entry, the fraction used and the step and shift of the blend.
   function automatic read_plan_type plan_reads(input logic [TIME_W-1:0] t);
      read_plan_type p;
      int unsigned   f;
      int unsigned   i0;
      int unsigned   i1;
      bit            dec2;
      bit            dec4;
      f    = t[TIME_W-1:FRAC_W];
      dec2 = cfg_mode[0];
      dec4 = !cfg_mode[0] && cfg_mode[1];
      p.rem   = {2'b00, t[FRAC_W-1:0]};
      p.step  = 3'd1;
      p.shift = 2'd0;
      p.raw   = 1'b0;
      if (cfg_frames != 0 && f == cfg_frames - 1) begin
         if (dec2) begin
            i0 = (f >> 1) + (f & 1);
         end else if (dec4) begin
            i0 = (f >> 2) + (f & 3);
         end else begin
            i0 = f;
         end
         i1    = 0;
         p.raw = !cfg_loop;
      end else if (dec2) begin
         if (f >= cfg_last) begin
            i0 = cfg_last >> 1;
         end else begin
            i0      = f >> 1;
            p.rem   = {1'b0, t[12:0]};
            p.step  = 3'd2;
            p.shift = 2'd1;
         end
         i1 = i0 + 1;
      end else if (dec4) begin
         if (f >= cfg_last) begin
            i0 = (f >> 2) + (f & 3);
         end else begin
            i0      = f >> 2;
            p.rem   = t[13:0];
            p.step  = 3'd4;
            p.shift = 2'd2;
         end
         i1 = i0 + 1;
      end else begin
         i0 = f;
         i1 = f + 1;
      end
      p.first  = ENTRY_W'(i0 % DEPTH);
      p.second = ENTRY_W'(i1 % DEPTH);
      return p;
   endfunction

   // Step-scaled linear blend from a toward b. Products and sums wrap at 32 bits and
   // both right shifts keep the sign.
   function automatic logic [VALUE_W-1:0] blend_fixed(input logic [VALUE_W-1:0] a,
                                                      input logic [VALUE_W-1:0] b,
                                                      input logic [REM_W-1:0]   rem,
                                                      input logic [2:0]         step,
                                                      input logic [1:0]         shift);
      logic [VALUE_W-1:0] prod;
      logic [VALUE_W-1:0] part;
      logic [VALUE_W-1:0] total;
      prod  = (b - a) * {18'd0, rem};
      part  = $signed(prod) >>> FRAC_W;
      total = a * {29'd0, step} + part;
      return $signed(total) >>> shift;
   endfunction

   // Random table value, leaning on the extremes and on values whose low half matters
   // to the narrow format.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Offers one beat on the request channel and holds it until the block takes it. A
   // random gap may come first; valid is only lowered in that case, so back-to-back
   // beats keep valid high.
   task automatic push_request(input logic [FUNC_W-1:0]  func,
                               input logic [ENTRY_W-1:0] entry,
                               input logic [VALUE_W-1:0] scale,
                               input logic [VALUE_W-1:0] inverse,
                               input logic [TIME_W-1:0]  frame_time,
                               input logic               typed,
                               input blend_pair_type     exp);
      int gap;
      if (idle_on && !calm_tail && $urandom_range(0, 99) < 15) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.func          <= func;
      req_if.entry_index   <= entry;
      req_if.scale_value   <= scale;
      req_if.inverse_value <= inverse;
      req_if.frame_time    <= frame_time;
      typed_pending        <= typed;
      typed_blend          <= exp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (func == FUNC_LOAD) begin
         loads_sent++;
      end else begin
         queries_sent++;
      end
   endtask

   // Load with random content at one table position.
   task automatic load_random_pair(input logic [ENTRY_W-1:0] entry);
      push_request(FUNC_LOAD, entry, pick_value(), pick_value(), TIME_W'($urandom), 1'b0,
                   NO_BLEND);
   endtask

   // The sender stops and waits until every owed result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_blends.size() != 0) @(posedge clock);
   endtask

   // A trailing load produces no response, so after the drain the bench also waits out the
   // settling margin before the block counts as idle.
   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      reg_writes++;
   endtask

   // The receiver stalls in random bursts while idling is on for the phase.
   initial begin : response_pacing
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (calm_tail || !idle_on) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 10) stall_left = $urandom_range(1, 17);
         end
      end
   end

   // Everything the block accepts is seen here at the rising edge: response beats are
   // checked against the oldest expectation, register beats update the settings copy,
   // load beats update the table copy and query beats add an expectation.
   always @(posedge clock) begin : beat_monitor
      read_plan_type      plan;
      blend_pair_type     got;
      blend_pair_type     want;
      logic [VALUE_W-1:0] s;
      logic [VALUE_W-1:0] v;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.scale_out, rsp_if.inverse_out};
            if (expected_blends.size() == 0) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN) begin
                  $display("Unexpected response beat: scale %h inverse %h", got.scale,
                           got.inverse);
               end
            end else begin
               want = expected_blends.pop_front();
               results_checked++;
               if (got.scale !== want.scale || got.inverse !== want.inverse) begin
                  mismatches++;
                  if (mismatches <= MISMATCH_SHOWN) begin
                     $display("Response mismatch: scale exp %h got %h, inverse exp %h got %h",
                              want.scale, got.scale, want.inverse, got.inverse);
                  end
               end
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_DECIMATION_MODE:   cfg_mode   = csr_if.data[MODE_W-1:0];
               CSR_LAST_INTERP_FRAME: cfg_last   = csr_if.data[LAST_W-1:0];
               CSR_NARROW_FORMAT:     cfg_narrow = csr_if.data[0];
               CSR_NUM_FRAMES:        cfg_frames = csr_if.data[FRAMES_W-1:0];
               CSR_LOOP_TO_START:     cfg_loop   = csr_if.data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.func == FUNC_LOAD) begin
               s = req_if.scale_value;
               v = req_if.inverse_value;
               if (cfg_narrow) begin
                  s = {{16{s[15]}}, s[15:0]};
                  v = {{16{v[15]}}, v[15:0]};
               end
               scale_table[req_if.entry_index % DEPTH]   = s;
               inverse_table[req_if.entry_index % DEPTH] = v;
               entry_loaded[req_if.entry_index % DEPTH]  = 1'b1;
            end else if (typed_pending) begin
               expected_blends.push_back(typed_blend);
            end else begin
               plan = plan_reads(req_if.frame_time);
               if (plan.raw) begin
                  want = {scale_table[plan.first], inverse_table[plan.first]};
               end else begin
                  want.scale   = blend_fixed(scale_table[plan.first],
                                             scale_table[plan.second],
                                             plan.rem, plan.step, plan.shift);
                  want.inverse = blend_fixed(inverse_table[plan.first],
                                             inverse_table[plan.second],
                                             plan.rem, plan.step, plan.shift);
               end
               expected_blends.push_back(want);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
                  expected_blends.size());
         $display("[keyframe_scale_interpolator_top] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int                 phase_start;
      int                 phase_len;
      int                 fr;
      int                 n_need;
      logic [ENTRY_W-1:0] need [3];
      logic [TIME_W-1:0]  t;
      logic [FRAC_W-1:0]  frac;
      read_plan_type      plan;

      // Every input is known from time zero; reset is asserted first and then released.
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.func          <= FUNC_LOAD;
      req_if.entry_index   <= '0;
      req_if.scale_value   <= '0;
      req_if.inverse_value <= '0;
      req_if.frame_time    <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= CSR_DECIMATION_MODE;
      csr_if.data          <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Register rows wait for the block to go idle first.
      settings_tried = 1;
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         case (DIRECTED_ROWS[r].kind)
            ROW_REG: begin
               settle_block();
               write_reg(DIRECTED_ROWS[r].regw.idx, DIRECTED_ROWS[r].regw.data);
               settings_tried++;
            end
            ROW_LOAD: begin
               push_request(FUNC_LOAD, DIRECTED_ROWS[r].entry, DIRECTED_ROWS[r].scale,
                            DIRECTED_ROWS[r].inverse, DIRECTED_ROWS[r].frame_time, 1'b0,
                            NO_BLEND);
            end
            default: begin
               push_request(FUNC_QUERY, DIRECTED_ROWS[r].entry, DIRECTED_ROWS[r].scale,
                            DIRECTED_ROWS[r].inverse, DIRECTED_ROWS[r].frame_time,
                            DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
            end
         endcase
      end

      // Random part, in phases. Each phase settles the block, picks a fresh setting of
      // all five registers with the extremes favoured, and then sends mostly queries.
      // A query aimed at an entry that was never loaded is preceded by loads of those
      // entries, so the table never hands back contents nobody wrote. The last phase
      // holds the calm items and runs without idling.
      while (items_sent < ITEM_TARGET) begin
         phase_len = $urandom_range(60, 140);
         if (ITEM_TARGET - items_sent <= CALM_ITEMS) begin
            phase_len = ITEM_TARGET - items_sent;
         end else if (ITEM_TARGET - items_sent < CALM_ITEMS + phase_len) begin
            phase_len = ITEM_TARGET - items_sent - CALM_ITEMS;
         end
         settle_block();
         calm_tail = (ITEM_TARGET - items_sent <= CALM_ITEMS);
         idle_on   = !calm_tail && ($urandom_range(0, 3) != 0);

         write_reg(CSR_DECIMATION_MODE, CSR_DATA_W'($urandom_range(0, 3)));
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_LAST_INTERP_FRAME, 16'd0);
            1:       write_reg(CSR_LAST_INTERP_FRAME, 16'd8191);
            2:       write_reg(CSR_LAST_INTERP_FRAME, CSR_DATA_W'($urandom_range(0, 40)));
            default: write_reg(CSR_LAST_INTERP_FRAME, CSR_DATA_W'($urandom_range(0, 8191)));
         endcase
         write_reg(CSR_NARROW_FORMAT, CSR_DATA_W'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0:       write_reg(CSR_NUM_FRAMES, 16'd0);
            1:       write_reg(CSR_NUM_FRAMES, 16'd1);
            2:       write_reg(CSR_NUM_FRAMES, 16'hFFFF);
            3:       write_reg(CSR_NUM_FRAMES, CSR_DATA_W'($urandom_range(2, 48)));
            default: write_reg(CSR_NUM_FRAMES, CSR_DATA_W'($urandom));
         endcase
         write_reg(CSR_LOOP_TO_START, CSR_DATA_W'($urandom_range(0, 1)));
         settings_tried++;

         phase_start = items_sent;
         while (items_sent - phase_start < phase_len) begin
            if ($urandom_range(0, 99) < 30) begin
               // Plain load, half of them into the low entries that queries use most.
               if ($urandom_range(0, 1)) begin
                  load_random_pair(ENTRY_W'($urandom_range(0, 63)));
               end else begin
                  load_random_pair(ENTRY_W'($urandom));
               end
            end else begin
               // Query aimed at the final frame, the last interpolated frame, the first
               // few frames, or anywhere at all.
               case ($urandom_range(0, 5))
                  0:       frac = '0;
                  1:       frac = '1;
                  default: frac = FRAC_W'($urandom);
               endcase
               case ($urandom_range(0, 3))
                  0: fr = (cfg_frames != 0) ? int'(cfg_frames) - 1 : $urandom_range(0, 65535);
                  1: fr = int'(cfg_last) + int'($urandom_range(0, 6)) - 3;
                  2: fr = $urandom_range(0, 40);
                  default: fr = $urandom_range(0, 65535);
               endcase
               if (fr < 0) fr = 0;
               t = {FRAME_W'(fr), frac};
               if ($urandom_range(0, 3) == 0) t = TIME_W'($urandom);

               plan = plan_reads(t);
               need[0] = plan.first;
               if (plan.raw) begin
                  need[1] = ENTRY_W'((plan.first + 1) % DEPTH);
                  need[2] = '0;
                  n_need  = 3;
               end else begin
                  need[1] = plan.second;
                  n_need  = 2;
               end
               for (int k = 0; k < n_need; k++) begin
                  if (!entry_loaded[need[k]]) load_random_pair(need[k]);
               end
               push_request(FUNC_QUERY, ENTRY_W'($urandom), $urandom, $urandom, t, 1'b0,
                            NO_BLEND);
            end
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(0, 149) == 0) drain_results();
         end
      end

      settle_block();
      $display("Covered %0d loads and %0d queries under %0d register settings (%0d writes).",
               loads_sent, queries_sent, settings_tried, reg_writes);
      $display("Checked %0d response beats; %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("[keyframe_scale_interpolator_top] OK");
      end else begin
         $display("[keyframe_scale_interpolator_top] ERROR");
      end
      $finish;
   end

endmodule
